>>> hdl/rmbd_pkg.sv
// Shared types, codes and helpers for the region map bus decoder.
package rmbd_pkg;

   localparam int DEFAULT_REGION_SLOTS = 16;
   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 3;
   localparam int SLOT_OUT_W = 4;

   typedef logic [2:0] kind_type;
   localparam kind_type KIND_READ  = 3'd0;
   localparam kind_type KIND_WRITE = 3'd1;
   localparam kind_type KIND_MAP   = 3'd2;
   localparam kind_type KIND_UNMAP = 3'd3;
   localparam kind_type KIND_MOVE  = 3'd4;

   typedef logic [2:0] route_type;
   localparam route_type ROUTE_HIT     = 3'd0;
   localparam route_type ROUTE_DEVICE  = 3'd1;
   localparam route_type ROUTE_FAULT   = 3'd2;
   localparam route_type ROUTE_DONE    = 3'd3;
   localparam route_type ROUTE_REFUSED = 3'd4;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [1:0]  size_code;
      logic [31:0] write_data;
      logic [31:0] region_length;
      logic        writable;
      logic [31:0] destination;
   } req_type;

   typedef struct packed {
      route_type              route;
      logic [SLOT_OUT_W-1:0]  slot;
      logic [31:0]            offset;
      logic [31:0]            store_data;
      logic [1:0]             width_out;
      logic                   bus_error;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic        contains_addr;
      logic        base_eq_addr;
      logic        map_blocked;
      logic        contains_dest;
      logic        dest_le_base;
      logic [31:0] base_minus_dest;
      logic [31:0] len;
      logic        writable;
      logic [31:0] offset;
      logic        past_end;
   } slot_stat_type;

   typedef struct packed {
      logic load;
      logic clear;
      logic move;
   } slot_cmd_type;

   function automatic logic [32:0] span_of(logic [1:0] size_code);
      return 33'd1 << size_code;
   endfunction

endpackage

>>> hdl/rmbd_region_slot.sv
// One region slot: stored region and its parallel range comparators.
module rmbd_region_slot (
   input  logic                   clock,
   input  logic                   reset,
   input  rmbd_pkg::slot_cmd_type cmd,
   input  rmbd_pkg::req_type      item,
   output rmbd_pkg::slot_stat_type stat
);
   import rmbd_pkg::*;

   logic        valid_ff, valid_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] len_ff, len_in;
   logic        writable_ff, writable_in;
   logic [31:0] addr_off, base_off, dest_off;
   logic        contains_addr;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load) begin
         valid_in = 1'b1;
      end else if (cmd.clear) begin
         valid_in = 1'b0;
      end
      base_in     = cmd.load ? item.address : (cmd.move ? item.destination : base_ff);
      len_in      = cmd.load ? item.region_length : len_ff;
      writable_in = cmd.load ? item.writable : writable_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      len_ff      <= len_in;
      writable_ff <= writable_in;
   end

   assign addr_off      = item.address - base_ff;
   assign base_off      = base_ff - item.address;
   assign dest_off      = item.destination - base_ff;
   assign contains_addr = valid_ff && (item.address >= base_ff) && (addr_off < len_ff);

   always_comb begin
      stat.valid           = valid_ff;
      stat.contains_addr   = contains_addr;
      stat.base_eq_addr    = (base_ff == item.address);
      stat.map_blocked     = valid_ff && (contains_addr ||
                             ((base_ff >= item.address) && (base_off < item.region_length)));
      stat.contains_dest   = valid_ff && (item.destination >= base_ff) && (dest_off < len_ff);
      stat.dest_le_base    = item.destination <= base_ff;
      stat.base_minus_dest = base_ff - item.destination;
      stat.len             = len_ff;
      stat.writable        = writable_ff;
      stat.offset          = addr_off;
      stat.past_end        = ({1'b0, addr_off} + span_of(item.size_code)) > {1'b0, len_ff};
   end

endmodule

>>> hdl/rmbd_decode.sv
// Slot priority selection, route decision and table update commands.
module rmbd_decode #(
   parameter int REGION_SLOTS = rmbd_pkg::DEFAULT_REGION_SLOTS
) (
   input  rmbd_pkg::req_type                          item,
   input  rmbd_pkg::slot_stat_type [REGION_SLOTS-1:0] stat,
   input  logic                                       bus_error_enable,
   output rmbd_pkg::rsp_type                          result,
   output rmbd_pkg::slot_cmd_type  [REGION_SLOTS-1:0] cmd
);
   import rmbd_pkg::*;

   localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

   logic                    hit_found, free_found, map_blocked_any, dest_blocked;
   logic [SLOT_W-1:0]       hit_idx, free_idx;
   logic [REGION_SLOTS-1:0] hit_sel, free_sel;
   slot_stat_type           hit_stat;
   logic                    map_ok, unmap_ok, move_ok;

   always_comb begin
      hit_found       = 1'b0;
      free_found      = 1'b0;
      map_blocked_any = 1'b0;
      hit_idx         = '0;
      free_idx        = '0;
      hit_sel         = '0;
      free_sel        = '0;
      hit_stat        = '0;
      for (int i = REGION_SLOTS - 1; i >= 0; i--) begin
         if (stat[i].contains_addr) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
            hit_sel   = REGION_SLOTS'(1) << i;
            hit_stat  = stat[i];
         end
         if (!stat[i].valid) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
            free_sel   = REGION_SLOTS'(1) << i;
         end
         if (stat[i].map_blocked) begin
            map_blocked_any = 1'b1;
         end
      end
   end

   always_comb begin
      dest_blocked = 1'b0;
      for (int i = 0; i < REGION_SLOTS; i++) begin
         if (stat[i].contains_dest ||
             (stat[i].valid && stat[i].dest_le_base &&
              (stat[i].base_minus_dest < hit_stat.len))) begin
            dest_blocked = 1'b1;
         end
      end
   end

   assign map_ok   = (item.kind == KIND_MAP) && !map_blocked_any && free_found;
   assign unmap_ok = (item.kind == KIND_UNMAP) && hit_found && hit_stat.base_eq_addr;
   assign move_ok  = (item.kind == KIND_MOVE) && hit_found && hit_stat.base_eq_addr &&
                     !dest_blocked;

   always_comb begin
      for (int i = 0; i < REGION_SLOTS; i++) begin
         cmd[i].load  = map_ok && free_sel[i];
         cmd[i].clear = unmap_ok && hit_sel[i];
         cmd[i].move  = move_ok && hit_sel[i];
      end
   end

   always_comb begin
      result       = '0;
      result.route = ROUTE_REFUSED;
      case (item.kind)
         KIND_READ, KIND_WRITE: begin
            result.width_out  = item.size_code;
            result.store_data = (item.kind == KIND_WRITE) ? item.write_data : 32'd0;
            if (!hit_found) begin
               result.route = ROUTE_DEVICE;
            end else begin
               result.slot   = SLOT_OUT_W'(hit_idx);
               result.offset = hit_stat.offset;
               if (((item.kind == KIND_WRITE) && !hit_stat.writable) || hit_stat.past_end) begin
                  result.route     = ROUTE_FAULT;
                  result.bus_error = bus_error_enable;
               end else begin
                  result.route = ROUTE_HIT;
               end
            end
         end
         KIND_MAP: begin
            if (map_ok) begin
               result.route = ROUTE_DONE;
               result.slot  = SLOT_OUT_W'(free_idx);
            end
         end
         KIND_UNMAP, KIND_MOVE: begin
            if (unmap_ok || move_ok) begin
               result.route = ROUTE_DONE;
               result.slot  = SLOT_OUT_W'(hit_idx);
            end
         end
         default: begin
            result.route = ROUTE_REFUSED;
         end
      endcase
   end

endmodule

>>> hdl/region_map_bus_decoder_unit.sv
// Top level of the region map bus decoder: stream ports, staging and result registers.
// An accepted request word is held in the staging register, and its response word in the result register.
// Throughput: one word per cycle while the response side does not stall; the slot comparators all work in parallel.
// Table updates land with the result register, so the next word sees them.
// Reset: synchronous, clears all slot valid bits, the bus error enable and both stages.
module region_map_bus_decoder_unit #(
   parameter int REGION_SLOTS = rmbd_pkg::DEFAULT_REGION_SLOTS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // address, size_code, write_data, region_length, writable, destination, zero pad
   input  logic [rmbd_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind
   input  logic [rmbd_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // slot, offset, store_data, width_out, bus_error, zero pad
   output logic [rmbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // route
   output logic [rmbd_pkg::RSP_USER_W-1:0] rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic                           csr_data
);
   import rmbd_pkg::*;

   logic                                s1_valid_ff, s1_valid_in;
   req_type                             req_ff, req_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   rsp_type                             rsp_ff, rsp_in;
   logic                                bus_error_enable_ff, bus_error_enable_in;
   logic                                advance, commit;
   slot_stat_type [REGION_SLOTS-1:0]    slot_stat;
   slot_cmd_type  [REGION_SLOTS-1:0]    slot_cmd_raw;
   slot_cmd_type  [REGION_SLOTS-1:0]    slot_cmd;
   logic          [REGION_SLOTS-1:0]    slot_valid;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign commit     = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_comb begin
      req_in.kind          = req_tuser[2:0];
      req_in.address       = req_tdata[31:0];
      req_in.size_code     = req_tdata[33:32];
      req_in.write_data    = req_tdata[65:34];
      req_in.region_length = req_tdata[97:66];
      req_in.writable      = req_tdata[98];
      req_in.destination   = req_tdata[130:99];
   end

   assign s1_valid_in  = (req_tvalid && req_tready) || (s1_valid_ff && !advance);
   assign rsp_valid_in = commit || (rsp_valid_ff && !rsp_tready);
   assign bus_error_enable_in = (csr_valid && csr_ready) ? csr_data : bus_error_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         bus_error_enable_ff <= 1'b0;
      end else begin
         s1_valid_ff         <= s1_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         bus_error_enable_ff <= bus_error_enable_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_ff <= req_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   for (genvar i = 0; i < REGION_SLOTS; i++) begin : g_slot
      assign slot_cmd[i]   = commit ? slot_cmd_raw[i] : '0;
      assign slot_valid[i] = slot_stat[i].valid;

      rmbd_region_slot u_slot (
         .clock (clock),
         .reset (reset),
         .cmd   (slot_cmd[i]),
         .item  (req_ff),
         .stat  (slot_stat[i])
      );
   end

   rmbd_decode #(
      .REGION_SLOTS (REGION_SLOTS)
   ) u_decode (
      .item             (req_ff),
      .stat             (slot_stat),
      .bus_error_enable (bus_error_enable_ff),
      .result           (rsp_in),
      .cmd              (slot_cmd_raw)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.route;
   assign rsp_tdata  = {1'b0, rsp_ff.bus_error, rsp_ff.width_out, rsp_ff.store_data,
                        rsp_ff.offset, rsp_ff.slot};

`ifndef SYNTHESIS
   a_berr_only_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.bus_error) |-> (rsp_ff.route == ROUTE_FAULT))
      else $error("bus error raised on a non-fault response");

   a_map_adds_slot: assert property (@(posedge clock) disable iff (reset)
      (commit && (req_ff.kind == KIND_MAP) && (rsp_in.route == ROUTE_DONE)) |=>
      ($countones(slot_valid) == $countones($past(slot_valid)) + 1))
      else $error("successful map did not add exactly one region");

   a_unmap_drops_slot: assert property (@(posedge clock) disable iff (reset)
      (commit && (req_ff.kind == KIND_UNMAP) && (rsp_in.route == ROUTE_DONE)) |=>
      ($countones(slot_valid) + 1 == $countones($past(slot_valid))))
      else $error("successful unmap did not drop exactly one region");

   a_table_held_when_stalled: assert property (@(posedge clock) disable iff (reset)
      !commit |=> (slot_valid == $past(slot_valid)))
      else $error("region table changed without a committed word");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the region map bus decoder: random and directed words, checked live.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rmbd_pkg::*;

   localparam int          SLOTS       = DEFAULT_REGION_SLOTS;
   localparam int          LONG_STALL  = 300;
   localparam int          DRAIN_TICKS = 6;
   localparam logic [31:0] ARENA_ORIGIN [3] = '{32'h0000_0000, 32'h8000_0000, 32'hFFFF_F000};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic                  csr_data   = 1'b0;

   req_type pending_words[$];
   rsp_type due_results[$];

   logic        map_valid    [SLOTS];
   logic [31:0] map_base     [SLOTS];
   logic [31:0] map_len      [SLOTS];
   logic        map_writable [SLOTS];
   logic        berr_enable  = 1'b0;

   int fail_count    = 0;
   int send_idle_max = 0;
   int take_idle_max = 0;
   int stalls_asked  = 0;
   int zero_len_left = 2;

   region_map_bus_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         map_valid[s]    = 1'b0;
         map_base[s]     = '0;
         map_len[s]      = '0;
         map_writable[s] = 1'b0;
      end
   end

   function automatic int lowest_hit(logic [31:0] a);
      for (int s = 0; s < SLOTS; s++)
         if (map_valid[s] && a >= map_base[s] && (a - map_base[s]) < map_len[s])
            return s;
      return -1;
   endfunction

   function automatic bit span_clear(logic [31:0] b, logic [31:0] n);
      for (int s = 0; s < SLOTS; s++) begin
         if (map_valid[s] && b <= map_base[s] && (map_base[s] - b) < n)
            return 1'b0;
         if (map_valid[s] && map_base[s] <= b && (b - map_base[s]) < map_len[s])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type decode_word(req_type w);
      rsp_type     r;
      int          s;
      logic [31:0] off;
      r = '0;
      r.route = ROUTE_REFUSED;
      case (w.kind)
         KIND_READ, KIND_WRITE: begin
            r.width_out = w.size_code;
            if (w.kind == KIND_WRITE)
               r.store_data = w.write_data;
            s = lowest_hit(w.address);
            if (s < 0) begin
               r.route = ROUTE_DEVICE;
            end else begin
               off = w.address - map_base[s];
               r.slot = s[SLOT_OUT_W-1:0];
               r.offset = off;
               if ((w.kind == KIND_WRITE && !map_writable[s]) ||
                   ({1'b0, off} + (33'd1 << w.size_code) > {1'b0, map_len[s]})) begin
                  r.route = ROUTE_FAULT;
                  r.bus_error = berr_enable;
               end else begin
                  r.route = ROUTE_HIT;
               end
            end
         end
         KIND_MAP: begin
            if (span_clear(w.address, w.region_length)) begin
               s = 0;
               while (s < SLOTS && map_valid[s])
                  s++;
               if (s < SLOTS) begin
                  map_valid[s]    = 1'b1;
                  map_base[s]     = w.address;
                  map_len[s]      = w.region_length;
                  map_writable[s] = w.writable;
                  r.route = ROUTE_DONE;
                  r.slot  = s[SLOT_OUT_W-1:0];
               end
            end
         end
         KIND_UNMAP: begin
            s = lowest_hit(w.address);
            if (s >= 0 && map_base[s] == w.address) begin
               map_valid[s] = 1'b0;
               r.route = ROUTE_DONE;
               r.slot  = s[SLOT_OUT_W-1:0];
            end
         end
         KIND_MOVE: begin
            s = lowest_hit(w.address);
            if (s >= 0 && map_base[s] == w.address && span_clear(w.destination, map_len[s])) begin
               map_base[s] = w.destination;
               r.route = ROUTE_DONE;
               r.slot  = s[SLOT_OUT_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : feed_requests
      req_type w;
      bit      offering;
      int      send_wait;
      if (reset) begin
         req_tvalid <= 1'b0;
         offering = 1'b0;
         send_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            offering = 1'b0;
            send_wait = $urandom_range(0, send_idle_max);
         end
         if (!offering) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_tdata <= {5'b0, w.destination, w.writable, w.region_length,
                             w.write_data, w.size_code, w.address};
               req_tuser <= w.kind;
               offering = 1'b1;
            end
         end
         req_tvalid <= offering;
      end
   end

   always @(posedge clock) begin : drain_results
      int take_wait;
      int stall_left;
      int stalls_served;
      if (reset) begin
         rsp_tready <= 1'b0;
         take_wait = 0;
         stall_left = 0;
         stalls_served = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            take_wait = $urandom_range(0, take_idle_max);
         if (stalls_served != stalls_asked) begin
            stalls_served = stalls_asked;
            stall_left = LONG_STALL;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (take_wait > 0) begin
            take_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watch_ports
      req_type word;
      rsp_type seen;
      rsp_type want;
      if (!reset) begin
         if (csr_valid && csr_ready)
            berr_enable = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            seen.route      = rsp_tuser;
            seen.slot       = rsp_tdata[3:0];
            seen.offset     = rsp_tdata[35:4];
            seen.store_data = rsp_tdata[67:36];
            seen.width_out  = rsp_tdata[69:68];
            seen.bus_error  = rsp_tdata[70];
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: route %0d slot %0d offset %h",
                           seen.route, seen.slot, seen.offset);
            end else begin
               want = due_results.pop_front();
               if (seen.route !== want.route || seen.slot !== want.slot ||
                   seen.offset !== want.offset || seen.store_data !== want.store_data ||
                   seen.width_out !== want.width_out || seen.bus_error !== want.bus_error) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display({"mismatch expected: route %0d slot %0d offset %h",
                               " data %h width %0d berr %0d"},
                              want.route, want.slot, want.offset, want.store_data,
                              want.width_out, want.bus_error);
                     $display({"         actual:   route %0d slot %0d offset %h",
                               " data %h width %0d berr %0d"},
                              seen.route, seen.slot, seen.offset, seen.store_data,
                              seen.width_out, seen.bus_error);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            word.kind          = req_tuser;
            word.address       = req_tdata[31:0];
            word.size_code     = req_tdata[33:32];
            word.write_data    = req_tdata[65:34];
            word.region_length = req_tdata[97:66];
            word.writable      = req_tdata[98];
            word.destination   = req_tdata[130:99];
            due_results.push_back(decode_word(word));
         end
      end
   end

   function automatic req_type make_req(kind_type k, logic [31:0] addr, logic [1:0] size,
                                        logic [31:0] wdata, logic [31:0] len, logic wr,
                                        logic [31:0] dest);
      req_type w;
      w.kind          = k;
      w.address       = addr;
      w.size_code     = size;
      w.write_data    = wdata;
      w.region_length = len;
      w.writable      = wr;
      w.destination   = dest;
      return w;
   endfunction

   function automatic logic [31:0] arena_spot(bit aligned);
      logic [31:0] a;
      a = ARENA_ORIGIN[$urandom_range(0, 2)] + ($urandom_range(0, 15) << 8);
      if (!aligned)
         a = a + $urandom_range(0, 255);
      return a;
   endfunction

   task automatic queue_mix(int count, int map_pct, bit short_len);
      req_type w;
      int      pick;
      for (int i = 0; i < count; i++) begin
         w.kind          = kind_type'($urandom_range(0, 7));
         w.address       = $urandom;
         w.size_code     = 2'($urandom_range(0, 3));
         w.write_data    = $urandom;
         w.region_length = $urandom;
         w.writable      = 1'($urandom_range(0, 1));
         w.destination   = $urandom;
         pick = $urandom_range(0, 99);
         if (pick >= 5 && pick < 5 + map_pct) begin
            w.kind = KIND_MAP;
            w.address = arena_spot($urandom_range(0, 3) != 0);
            w.region_length = short_len ? $urandom_range(1, 'h80) : $urandom_range(1, 'h300);
            if (zero_len_left > 0 && $urandom_range(0, 63) == 0) begin
               w.region_length = '0;
               zero_len_left--;
            end
         end else if (pick >= 5) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
               w.kind = (pick < 40) ? KIND_READ : KIND_WRITE;
               w.address = arena_spot(1'b1) + $urandom_range(0, 'h2FF);
            end else begin
               w.kind = (pick < 87) ? KIND_UNMAP : KIND_MOVE;
               w.address = arena_spot(1'b1);
               w.destination = arena_spot($urandom_range(0, 3) != 0);
            end
         end
         pending_words.push_back(w);
      end
   endtask

   task automatic wait_drained();
      do
         @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || due_results.size() != 0);
      repeat (DRAIN_TICKS) @(negedge clock);
   endtask

   task automatic write_berr_enable(logic v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do
         @(posedge clock);
      while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // clear every removable region, then load the new enable while idle
   task automatic settle_then(logic v);
      wait_drained();
      for (int s = 0; s < SLOTS; s++)
         if (map_valid[s] && map_len[s] != 0)
            pending_words.push_back(make_req(KIND_UNMAP, map_base[s], 2'd0, '0, '0, 1'b0, '0));
      wait_drained();
      write_berr_enable(v);
   endtask

   initial begin : stimulus
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_berr_enable(1'b0);

      send_idle_max = 18;
      take_idle_max = 18;
      pending_words.push_back(make_req(KIND_READ,  32'h0000_0000, 2'd0, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_1000, 2'd0, '0, 32'h100, 1'b1, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_2000, 2'd0, '0, 32'h10, 1'b0, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_10F0, 2'd0, '0, 32'h100, 1'b1, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_0F00, 2'd0, '0, 32'h200, 1'b1, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_3000, 2'd0, '0, 32'h0, 1'b1, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_2FFF, 2'd0, '0, 32'h2, 1'b1, '0));
      pending_words.push_back(make_req(KIND_READ,  32'h0000_3000, 2'd1, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_UNMAP, 32'h0000_3000, 2'd0, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'hFFFF_FFF0, 2'd0, '0, 32'h100, 1'b1, '0));
      pending_words.push_back(make_req(KIND_READ,  32'hFFFF_FFFF, 2'd0, '1, '1, 1'b1, '1));
      pending_words.push_back(make_req(KIND_READ,  32'h0000_10FE, 2'd2, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_WRITE, 32'h0000_2000, 2'd0, '1, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_WRITE, 32'h0000_1000, 2'd3, 32'hA5A5_5A5A, '0,
                                       1'b0, '0));
      pending_words.push_back(make_req(KIND_READ,  32'h0000_10F9, 2'd3, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_MOVE,  32'h0000_1000, 2'd0, '0, '0, 1'b0,
                                       32'h0000_1080));
      pending_words.push_back(make_req(KIND_MOVE,  32'h0000_1004, 2'd0, '0, '0, 1'b0,
                                       32'h0000_5000));
      pending_words.push_back(make_req(KIND_MOVE,  32'h0000_1000, 2'd0, '0, '0, 1'b0,
                                       32'h0000_5000));
      pending_words.push_back(make_req(KIND_UNMAP, 32'h0000_5000, 2'd0, '0, '0, 1'b0, '0));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_7000, 2'd0, '0, 32'h40, 1'b0, '0));
      for (int k = 1; k <= 3; k++)
         pending_words.push_back(make_req(kind_type'(KIND_MOVE + k), '1, 2'd3, '1, '1, 1'b1, '1));
      pending_words.push_back(make_req(KIND_MAP,   32'h0000_0000, 2'd0, '0, '1, 1'b1, '0));
      wait_drained();
      write_berr_enable(1'b1);
      pending_words.push_back(make_req(KIND_WRITE, 32'h0000_2000, 2'd1, 32'h1234_5678, '0,
                                       1'b0, '0));
      pending_words.push_back(make_req(KIND_READ,  32'h0000_703E, 2'd2, '0, '0, 1'b0, '0));

      settle_then(1'b1);
      queue_mix(120, 25, 1'b0);

      settle_then(1'b0);
      send_idle_max = 0;
      take_idle_max = 0;
      queue_mix(120, 60, 1'b1);

      settle_then(1'b1);
      take_idle_max = 4;
      stalls_asked++;
      queue_mix(150, 25, 1'b0);

      settle_then(1'b0);
      send_idle_max = 18;
      take_idle_max = 0;
      queue_mix(60, 30, 1'b0);
      wait_drained();
      queue_mix(60, 30, 1'b0);

      settle_then(1'b1);
      send_idle_max = 4;
      take_idle_max = 18;
      queue_mix(120, 25, 1'b1);

      settle_then(1'b0);
      send_idle_max = $urandom_range(0, 18);
      take_idle_max = $urandom_range(0, 18);
      queue_mix(120, 25, 1'b0);

      wait_drained();
      if (fail_count == 0 && due_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
